// ===== design/uga_pkg.sv =====
// Shared types, constants and range-table functions for the UTF-8 glyph address mapper.
package uga_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam int CP_W   = 21;
    localparam int ADDR_W = 21;
    localparam int LEN_W  = 6;
    localparam int OFS_W  = 16;

    localparam logic [LEN_W-1:0] GLYPH_BYTES_12 = LEN_W'(25);
    localparam logic [LEN_W-1:0] GLYPH_BYTES_16 = LEN_W'(33);

    localparam logic [5:0] CONT_MASK = 6'h3f;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BAD_CONT  = 2'd1,
        ST_NO_GLYPH  = 2'd2,
        ST_BAD_LEAD  = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        RG_NONE,
        RG_ASCII,
        RG_CJK,
        RG_CJK_PUNCT,
        RG_GEN_PUNCT,
        RG_COMPAT,
        RG_FULLWIDTH
    } range_t;

    typedef struct packed {
        logic [CP_W-1:0] code_point;
        status_t         status;
        range_t          rng;
        logic            string_end;
    } dec_item_t;

    function automatic range_t glyph_range(input logic [CP_W-1:0] cp);
        range_t r;
        r = RG_NONE;
        if (cp >= CP_W'(32) && cp <= CP_W'(126)) begin
            r = RG_ASCII;
        end
        else if (cp >= CP_W'(20'h4e00) && cp <= CP_W'(20'h9fff)) begin
            r = RG_CJK;
        end
        else if (cp >= CP_W'(20'h3000) && cp <= CP_W'(20'h303f)) begin
            r = RG_CJK_PUNCT;
        end
        else if (cp >= CP_W'(20'h2000) && cp <= CP_W'(20'h206f)) begin
            r = RG_GEN_PUNCT;
        end
        else if (cp >= CP_W'(20'hfe30) && cp <= CP_W'(20'hfe4f)) begin
            r = RG_COMPAT;
        end
        else if (cp >= CP_W'(20'hff00) && cp <= CP_W'(20'hffef)) begin
            r = RG_FULLWIDTH;
        end
        return r;
    endfunction

    function automatic logic [OFS_W-1:0] range_low(input range_t r);
        logic [OFS_W-1:0] lo;
        unique case (r)
            RG_ASCII:     lo = OFS_W'(16'h0020);
            RG_CJK:       lo = OFS_W'(16'h4e00);
            RG_CJK_PUNCT: lo = OFS_W'(16'h3000);
            RG_GEN_PUNCT: lo = OFS_W'(16'h2000);
            RG_COMPAT:    lo = OFS_W'(16'hfe30);
            RG_FULLWIDTH: lo = OFS_W'(16'hff00);
            default:      lo = '0;
        endcase
        return lo;
    endfunction

    function automatic logic [ADDR_W-1:0] range_base(input range_t r, input logic big);
        logic [ADDR_W-1:0] b;
        unique case (r)
            RG_ASCII:     b = big ? ADDR_W'(538375)  : ADDR_W'(0);
            RG_CJK:       b = big ? ADDR_W'(541510)  : ADDR_W'(2375);
            RG_CJK_PUNCT: b = big ? ADDR_W'(1234246) : ADDR_W'(527175);
            RG_GEN_PUNCT: b = big ? ADDR_W'(1236358) : ADDR_W'(528775);
            RG_COMPAT:    b = big ? ADDR_W'(1240054) : ADDR_W'(531575);
            RG_FULLWIDTH: b = big ? ADDR_W'(1241110) : ADDR_W'(532375);
            default:      b = '0;
        endcase
        return b;
    endfunction

endpackage

// ===== design/uga_byte_if.sv =====
// Request channel carrying one UTF-8 byte and its end-of-string flag.
interface uga_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       end_of_string;

    modport source (output valid, output byte_value, output end_of_string, input ready);
    modport sink   (input valid, input byte_value, input end_of_string, output ready);
endinterface

// ===== design/uga_glyph_if.sv =====
// Request channel carrying one glyph lookup result.
interface uga_glyph_if;
    logic        valid;
    logic        ready;
    logic [20:0] glyph_address;
    logic [5:0]  glyph_bytes;
    logic [20:0] code_point;
    logic [1:0]  status;
    logic        string_end;

    modport source (output valid, output glyph_address, output glyph_bytes,
                    output code_point, output status, output string_end, input ready);
    modport sink   (input valid, input glyph_address, input glyph_bytes,
                    input code_point, input status, input string_end, output ready);
endinterface

// ===== design/utf8_glyph_address_mapper_top.sv =====
// Top level of the UTF-8 decoder with font glyph address lookup.
//
// The byte_in channel takes one UTF-8 byte per request, with end_of_string
// set on the last byte of a string. The glyph_out channel returns at most one
// result per byte: the glyph address and record length in font flash, the
// decoded code point, a status and the end-of-string mark.
// A result is written into the queue when the byte that completes it is accepted,
// then moves into the output register and is presented from there; a stall can hold it in between.
// The block accepts one byte per cycle and delivers one result per cycle while the receiver
// does not stall; the decoder, the queue and the address stage each pass one item a cycle.
// The font size register, written through cfg_we and cfg_wdata, selects 25-byte or 33-byte
// glyph records; the user must write it only while the block is idle, which it does not enforce.
// Reset clears the decoder state, empties the queue and drops any result.
// When the receiver stalls, the output register holds its result, the queue
// fills, and byte_in.ready falls once the queue is full.
module utf8_glyph_address_mapper_top #(
    parameter int QUEUE_DEPTH = uga_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    uga_byte_if.sink     byte_in,
    uga_glyph_if.source  glyph_out,
    input  logic         cfg_we,
    input  logic         cfg_wdata
);
    import uga_pkg::*;

    logic      font_size_reg;
    logic      push_valid;
    logic      push_ready;
    dec_item_t push_item;
    logic      pop_valid;
    logic      pop_ready;
    dec_item_t pop_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            font_size_reg <= 1'b0;
        end
        else if (cfg_we) begin
            font_size_reg <= cfg_wdata;
        end
    end

    uga_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_in    (byte_in),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready)
    );

    uga_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    uga_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .font_size (font_size_reg),
        .pop_valid (pop_valid),
        .pop_item  (pop_item),
        .pop_ready (pop_ready),
        .glyph_out (glyph_out)
    );

endmodule

// ===== design/uga_front.sv =====
// Front end: accepts bytes, runs the UTF-8 decoder and classifies each code point.
module uga_front (
    input  logic               clk,
    input  logic               rst_n,
    uga_byte_if.sink           byte_in,
    output logic               push_valid,
    output uga_pkg::dec_item_t push_item,
    input  logic               push_ready
);
    import uga_pkg::*;

    logic [1:0]      pending_reg, pending_next;
    logic [CP_W-1:0] partial_reg, partial_next;
    logic            aborted_reg, aborted_next;

    logic            accept;
    logic            emit;
    status_t         st;
    logic [CP_W-1:0] cp_out;
    range_t          rng_out;
    logic [7:0]      b;
    logic            eos;
    logic [CP_W-1:0] cont_cp;
    logic [CP_W-1:0] ascii_cp;
    range_t          rng_cont;
    range_t          rng_ascii;
    logic [1:0]      pend_dec;

    assign b        = byte_in.byte_value;
    assign eos      = byte_in.end_of_string;
    assign accept   = byte_in.valid && push_ready;
    assign cont_cp  = {partial_reg[CP_W-7:0], b[5:0] & CONT_MASK};
    assign ascii_cp = CP_W'(b);
    assign rng_cont = glyph_range(cont_cp);
    assign rng_ascii = glyph_range(ascii_cp);
    assign pend_dec = pending_reg - 2'd1;

    always_comb
    begin
        emit         = 1'b0;
        st           = ST_OK;
        cp_out       = '0;
        rng_out      = RG_NONE;
        pending_next = pending_reg;
        partial_next = partial_reg;
        aborted_next = aborted_reg;
        if (accept) begin
            if (aborted_reg) begin
                emit = 1'b0;
            end
            else if (pending_reg != 2'd0) begin
                if (b[7:6] != 2'b10) begin
                    emit         = 1'b1;
                    st           = ST_BAD_CONT;
                    cp_out       = partial_reg;
                    pending_next = 2'd0;
                    partial_next = '0;
                end
                else begin
                    pending_next = pend_dec;
                    partial_next = cont_cp;
                    if (pend_dec == 2'd0) begin
                        emit         = 1'b1;
                        cp_out       = cont_cp;
                        rng_out      = rng_cont;
                        st           = (rng_cont == RG_NONE) ? ST_NO_GLYPH : ST_OK;
                        partial_next = '0;
                    end
                    else if (eos) begin
                        emit   = 1'b1;
                        st     = ST_BAD_CONT;
                        cp_out = cont_cp;
                    end
                end
            end
            else begin
                priority if (b[7] == 1'b0) begin
                    emit    = 1'b1;
                    cp_out  = ascii_cp;
                    rng_out = rng_ascii;
                    st      = (rng_ascii == RG_NONE) ? ST_NO_GLYPH : ST_OK;
                end
                else if (b[7:5] == 3'b110) begin
                    partial_next = CP_W'(b[4:0]);
                    pending_next = 2'd1;
                end
                else if (b[7:4] == 4'b1110) begin
                    partial_next = CP_W'(b[3:0]);
                    pending_next = 2'd2;
                end
                else if (b[7:3] == 5'b11110) begin
                    partial_next = CP_W'(b[2:0]);
                    pending_next = 2'd3;
                end
                else begin
                    emit   = 1'b1;
                    st     = ST_BAD_LEAD;
                    cp_out = ascii_cp;
                end
                if (b[7:6] == 2'b11 && b[7:3] != 5'b11111 && eos) begin
                    emit   = 1'b1;
                    st     = ST_BAD_CONT;
                    cp_out = partial_next;
                end
            end
            if (eos) begin
                pending_next = 2'd0;
                partial_next = '0;
                aborted_next = 1'b0;
            end
            else if (emit && (st == ST_BAD_CONT || st == ST_NO_GLYPH)) begin
                aborted_next = 1'b1;
                pending_next = 2'd0;
                partial_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            aborted_reg <= 1'b0;
        end
        else begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            aborted_reg <= aborted_next;
        end
    end

    assign byte_in.ready          = push_ready;
    assign push_valid             = accept && emit;
    assign push_item.code_point   = cp_out;
    assign push_item.status       = st;
    assign push_item.rng          = rng_out;
    assign push_item.string_end   = eos;

endmodule

// ===== design/uga_queue.sv =====
// Small FIFO of decoded code points between the decoder and the address stage.
module uga_queue #(
    parameter int DEPTH = uga_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push_valid,
    input  uga_pkg::dec_item_t push_item,
    output logic               push_ready,
    output logic               pop_valid,
    output uga_pkg::dec_item_t pop_item,
    input  logic               pop_ready
);
    import uga_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    dec_item_t       mem_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            push;
    logic            pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_ready && pop_valid;
    assign pop_item   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CW'(1);
        end
        else if (pop && !push) begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== design/uga_back.sv =====
// Back end: turns a classified code point into a glyph address and length.
module uga_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               font_size,
    input  logic               pop_valid,
    input  uga_pkg::dec_item_t pop_item,
    output logic               pop_ready,
    uga_glyph_if.source        glyph_out
);
    import uga_pkg::*;

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg;
    logic [LEN_W-1:0]  len_reg;
    logic [CP_W-1:0]   cp_reg;
    status_t           status_reg;
    logic              end_reg;

    logic              pop;
    logic [OFS_W-1:0]  ofs;
    logic [ADDR_W-1:0] ofs_w;
    logic [ADDR_W-1:0] scaled;
    logic [ADDR_W-1:0] addr_calc;
    logic              ok;

    assign pop_ready = !valid_reg || glyph_out.ready;
    assign pop       = pop_valid && pop_ready;
    assign ok        = (pop_item.status == ST_OK);
    assign ofs       = pop_item.code_point[OFS_W-1:0] - range_low(pop_item.rng);
    assign ofs_w     = ADDR_W'(ofs);
    assign scaled    = font_size ? ((ofs_w << 5) + ofs_w)
                                 : ((ofs_w << 4) + (ofs_w << 3) + ofs_w);
    assign addr_calc = range_base(pop_item.rng, font_size) + scaled;

    always_comb
    begin
        valid_next = valid_reg;
        if (pop) begin
            valid_next = 1'b1;
        end
        else if (glyph_out.ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            addr_reg   <= ok ? addr_calc : '0;
            len_reg    <= ok ? (font_size ? GLYPH_BYTES_16 : GLYPH_BYTES_12) : '0;
            cp_reg     <= pop_item.code_point;
            status_reg <= pop_item.status;
            end_reg    <= pop_item.string_end;
        end
    end

    assign glyph_out.valid         = valid_reg;
    assign glyph_out.glyph_address = addr_reg;
    assign glyph_out.glyph_bytes   = len_reg;
    assign glyph_out.code_point    = cp_reg;
    assign glyph_out.status        = status_reg;
    assign glyph_out.string_end    = end_reg;

endmodule

// ===== tb/tb_utf8_glyph_address_mapper_top.sv =====
// Testbench for the UTF-8 glyph address mapper: random and directed byte strings checked against a predictor.
module tb_utf8_glyph_address_mapper_top;
    timeunit 1ns;
    timeprecision 1ps;

    import uga_pkg::*;

    localparam int IDLE_LIMIT   = 1000;
    localparam int PHASE_BYTES  = 100;
    localparam int LONG_HOLD    = 80;
    localparam int SETTLE       = 8;

    typedef struct {
        logic [7:0] value;
        logic       eos;
    } byte_req_t;

    typedef struct {
        logic [ADDR_W-1:0] glyph_address;
        logic [LEN_W-1:0]  glyph_bytes;
        logic [CP_W-1:0]   code_point;
        status_t           status;
        logic              string_end;
    } glyph_t;

    class glyph_tracker;
        bit              font_big;
        logic [1:0]      cont_left;
        logic [CP_W-1:0] partial_cp;
        bit              dropping;
        glyph_t          expected_glyphs[$];
        int              errors;

        function new();
            font_big   = 0;
            cont_left  = '0;
            partial_cp = '0;
            dropping   = 0;
            errors     = 0;
        endfunction

        function glyph_t glyph_for(logic [CP_W-1:0] cp, logic eos);
            int unsigned lo;
            int unsigned b12;
            int unsigned b16;
            bit          hit;
            glyph_t      g;
            hit = 1;
            lo  = 0;
            b12 = 0;
            b16 = 0;
            if (cp >= 'h20 && cp <= 'h7e) begin
                lo = 'h20; b12 = 0; b16 = 538375;
            end
            else if (cp >= 'h4e00 && cp <= 'h9fff) begin
                lo = 'h4e00; b12 = 2375; b16 = 541510;
            end
            else if (cp >= 'h3000 && cp <= 'h303f) begin
                lo = 'h3000; b12 = 527175; b16 = 1234246;
            end
            else if (cp >= 'h2000 && cp <= 'h206f) begin
                lo = 'h2000; b12 = 528775; b16 = 1236358;
            end
            else if (cp >= 'hfe30 && cp <= 'hfe4f) begin
                lo = 'hfe30; b12 = 531575; b16 = 1240054;
            end
            else if (cp >= 'hff00 && cp <= 'hffef) begin
                lo = 'hff00; b12 = 532375; b16 = 1241110;
            end
            else begin
                hit = 0;
            end
            g.code_point = cp;
            g.string_end = eos;
            if (hit) begin
                g.status        = ST_OK;
                g.glyph_bytes   = font_big ? LEN_W'(33) : LEN_W'(25);
                g.glyph_address = font_big ? ADDR_W'(b16 + (int'(cp) - lo) * 33)
                                           : ADDR_W'(b12 + (int'(cp) - lo) * 25);
            end
            else begin
                g.status        = ST_NO_GLYPH;
                g.glyph_bytes   = '0;
                g.glyph_address = '0;
            end
            return g;
        endfunction

        function glyph_t failed_glyph(logic [CP_W-1:0] cp, status_t st, logic eos);
            glyph_t g;
            g.glyph_address = '0;
            g.glyph_bytes   = '0;
            g.code_point    = cp;
            g.status        = st;
            g.string_end    = eos;
            return g;
        endfunction

        function void note_byte(logic [7:0] b, logic eos);
            glyph_t     g;
            bit         produced;
            logic [1:0] need;
            produced = 0;
            need     = '0;
            if (dropping) begin
                produced = 0;
            end
            else if (cont_left != 0) begin
                if (b[7:6] != 2'b10) begin
                    g          = failed_glyph(partial_cp, ST_BAD_CONT, eos);
                    produced   = 1;
                    cont_left  = '0;
                    partial_cp = '0;
                end
                else begin
                    partial_cp = {partial_cp[CP_W-7:0], b[5:0]};
                    cont_left  = cont_left - 2'd1;
                    if (cont_left == 0) begin
                        g          = glyph_for(partial_cp, eos);
                        produced   = 1;
                        partial_cp = '0;
                    end
                    else if (eos) begin
                        g        = failed_glyph(partial_cp, ST_BAD_CONT, 1'b1);
                        produced = 1;
                    end
                end
            end
            else begin
                casez (b)
                    8'b0???????: begin
                        g        = glyph_for(CP_W'(b), eos);
                        produced = 1;
                    end
                    8'b110?????: begin
                        partial_cp = CP_W'(b[4:0]);
                        need       = 2'd1;
                    end
                    8'b1110????: begin
                        partial_cp = CP_W'(b[3:0]);
                        need       = 2'd2;
                    end
                    8'b11110???: begin
                        partial_cp = CP_W'(b[2:0]);
                        need       = 2'd3;
                    end
                    default: begin
                        g        = failed_glyph(CP_W'(b), ST_BAD_LEAD, eos);
                        produced = 1;
                    end
                endcase
                if (need != 0) begin
                    cont_left = need;
                    if (eos) begin
                        g        = failed_glyph(partial_cp, ST_BAD_CONT, 1'b1);
                        produced = 1;
                    end
                end
            end

            if (eos) begin
                cont_left  = '0;
                partial_cp = '0;
                dropping   = 0;
            end
            else if (produced && (g.status == ST_BAD_CONT || g.status == ST_NO_GLYPH)) begin
                dropping   = 1;
                cont_left  = '0;
                partial_cp = '0;
            end
            if (produced) begin
                expected_glyphs.push_back(g);
            end
        endfunction

        task report(string what, longint got, longint want);
            errors++;
            if (errors <= 200) begin
                $display("mismatch in %s: got %0h, expected %0h", what, got, want);
            end
        endtask

        task check_glyph(glyph_t got);
            glyph_t want;
            if (expected_glyphs.size() == 0) begin
                report("unexpected result code_point", got.code_point, 0);
                return;
            end
            want = expected_glyphs.pop_front();
            if (got.glyph_address !== want.glyph_address) begin
                report("glyph_address", got.glyph_address, want.glyph_address);
            end
            if (got.glyph_bytes !== want.glyph_bytes) begin
                report("glyph_bytes", got.glyph_bytes, want.glyph_bytes);
            end
            if (got.code_point !== want.code_point) begin
                report("code_point", got.code_point, want.code_point);
            end
            if (got.status !== want.status) begin
                report("status", got.status, want.status);
            end
            if (got.string_end !== want.string_end) begin
                report("string_end", got.string_end, want.string_end);
            end
        endtask
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic cfg_wdata;

    uga_byte_if  byte_ch();
    uga_glyph_if glyph_ch();

    utf8_glyph_address_mapper_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_in   (byte_ch),
        .glyph_out (glyph_ch),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    glyph_tracker tracker;
    byte_req_t    text_bytes[$];
    bit           long_hold_req;
    int           idle_cycles = 0;

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    function automatic void add_byte(logic [7:0] v, logic eos);
        byte_req_t r;
        r.value = v;
        r.eos   = eos;
        text_bytes.push_back(r);
    endfunction

    function automatic void add_char(logic [CP_W-1:0] cp, int len, bit last);
        logic [7:0] enc[4];
        case (len)
            1: begin
                enc[0] = {1'b0, cp[6:0]};
            end
            2: begin
                enc[0] = {3'b110, cp[10:6]};
                enc[1] = {2'b10, cp[5:0]};
            end
            3: begin
                enc[0] = {4'b1110, cp[15:12]};
                enc[1] = {2'b10, cp[11:6]};
                enc[2] = {2'b10, cp[5:0]};
            end
            default: begin
                enc[0] = {5'b11110, cp[20:18]};
                enc[1] = {2'b10, cp[17:12]};
                enc[2] = {2'b10, cp[11:6]};
                enc[3] = {2'b10, cp[5:0]};
            end
        endcase
        for (int i = 0; i < len; i++) begin
            add_byte(enc[i], last && (i == len - 1));
        end
    endfunction

    function automatic logic [CP_W-1:0] pick_code_point();
        logic [CP_W-1:0] edges[24] = '{
            'h1f, 'h20, 'h7e, 'h7f, 'h4dff, 'h4e00, 'h9fff, 'ha000,
            'h2fff, 'h3000, 'h303f, 'h3040, 'h1fff, 'h2000, 'h206f, 'h2070,
            'hfe2f, 'hfe30, 'hfe4f, 'hfe50, 'hfeff, 'hff00, 'hffef, 'hfff0
        };
        int r;
        r = $urandom_range(0, 99);
        if (r < 25) begin
            return CP_W'($urandom_range('h20, 'h7e));
        end
        else if (r < 45) begin
            return CP_W'($urandom_range('h4e00, 'h9fff));
        end
        else if (r < 55) begin
            return CP_W'($urandom_range('h3000, 'h303f));
        end
        else if (r < 65) begin
            return CP_W'($urandom_range('h2000, 'h206f));
        end
        else if (r < 72) begin
            return CP_W'($urandom_range('hfe30, 'hfe4f));
        end
        else if (r < 82) begin
            return CP_W'($urandom_range('hff00, 'hffef));
        end
        else if (r < 92) begin
            return edges[$urandom_range(0, 23)];
        end
        return CP_W'($urandom);
    endfunction

    function automatic void add_string();
        int              start;
        int              n;
        int              kind;
        int              len;
        int              cut;
        logic [CP_W-1:0] cp;
        start = text_bytes.size();
        kind  = $urandom_range(0, 99);
        if (kind < 8) begin
            n = $urandom_range(1, 6);
            for (int i = 0; i < n; i++) begin
                add_byte(8'($urandom), 1'b0);
            end
        end
        else begin
            n = $urandom_range(1, 8);
            for (int i = 0; i < n; i++) begin
                cp  = pick_code_point();
                len = (cp < 'h80) ? 1 : (cp < 'h800) ? 2 : (cp < 'h10000) ? 3 : 4;
                if (len < 4 && $urandom_range(0, 19) == 0) begin
                    len++;
                end
                add_char(cp, len, 1'b0);
            end
            if (kind < 16) begin
                text_bytes[$urandom_range(start, text_bytes.size() - 1)].value = 8'($urandom);
            end
            else if (kind < 22) begin
                cut = $urandom_range(1, text_bytes.size() - start);
                while (text_bytes.size() > start + cut) begin
                    void'(text_bytes.pop_back());
                end
            end
        end
        text_bytes[$].eos = 1'b1;
    endfunction

    task automatic send_bytes();
        byte_req_t item;
        int        left;
        int        gap;
        left = $urandom_range(1, 16);
        while (text_bytes.size() > 0) begin
            item = text_bytes.pop_front();
            byte_ch.valid         <= 1'b1;
            byte_ch.byte_value    <= item.value;
            byte_ch.end_of_string <= item.eos;
            @(posedge clk);
            while (!byte_ch.ready) begin
                @(posedge clk);
            end
            tracker.note_byte(item.value, item.eos);
            @(negedge clk);
            left--;
            if (text_bytes.size() == 0) begin
                byte_ch.valid <= 1'b0;
            end
            else if (left == 0) begin
                left = $urandom_range(1, 16);
                gap  = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 5);
                if (gap > 0) begin
                    byte_ch.valid <= 1'b0;
                    repeat (gap) @(negedge clk);
                end
            end
        end
    endtask

    task automatic wait_drained();
        while (tracker.expected_glyphs.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic set_font_size(bit big);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_wdata <= big;
        @(negedge clk);
        cfg_we <= 1'b0;
        tracker.font_big = big;
        @(negedge clk);
    endtask

    // The receiver switches between stall patterns and honors one long hold-off.
    initial
    begin : glyph_sink
        int seg_left;
        int mode;
        int tick;
        seg_left = 0;
        mode     = 0;
        tick     = 0;
        glyph_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            tick++;
            if (long_hold_req) begin
                long_hold_req = 0;
                glyph_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(negedge clk);
            end
            else begin
                if (seg_left == 0) begin
                    seg_left = $urandom_range(10, 60);
                    mode     = $urandom_range(0, 3);
                end
                seg_left--;
                case (mode)
                    0: glyph_ch.ready <= 1'b1;
                    1: glyph_ch.ready <= 1'($urandom_range(0, 1));
                    2: glyph_ch.ready <= (tick % 3 == 0);
                    default: glyph_ch.ready <= ($urandom_range(0, 5) != 0);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : take_glyph
        glyph_t got;
        if (rst_n && glyph_ch.valid && glyph_ch.ready) begin
            got.glyph_address = glyph_ch.glyph_address;
            got.glyph_bytes   = glyph_ch.glyph_bytes;
            got.code_point    = glyph_ch.code_point;
            got.status        = status_t'(glyph_ch.status);
            got.string_end    = glyph_ch.string_end;
            tracker.check_glyph(got);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n) begin
            if ((byte_ch.valid && byte_ch.ready) || (glyph_ch.valid && glyph_ch.ready)) begin
                idle_cycles <= 0;
            end
            else if (idle_cycles >= IDLE_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
            else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    initial
    begin
        tracker               = new();
        long_hold_req         = 0;
        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_wdata             = 1'b0;
        byte_ch.valid         = 1'b0;
        byte_ch.byte_value    = 8'h00;
        byte_ch.end_of_string = 1'b0;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_font_size(1'b0);
        add_char('h41, 1, 1'b0);
        add_char('h20, 1, 1'b0);
        add_char('h7e, 1, 1'b0);
        add_byte(8'h80, 1'b0);
        add_byte(8'hff, 1'b0);
        add_char('h4e00, 3, 1'b0);
        add_char('ha9, 2, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h41, 1'b1);
        add_char('h1fffff, 4, 1'b1);
        add_byte(8'he3, 1'b0);
        add_byte(8'h41, 1'b0);
        add_byte(8'h00, 1'b1);
        add_byte(8'he2, 1'b0);
        add_byte(8'h80, 1'b1);
        add_byte(8'hc3, 1'b1);
        add_byte(8'h00, 1'b1);
        add_char('h41, 2, 1'b0);
        add_char('hffef, 3, 1'b1);
        send_bytes();

        for (int phase = 0; phase < 4; phase++) begin
            set_font_size(phase % 2 == 0);
            while (text_bytes.size() < PHASE_BYTES) begin
                add_string();
            end
            if (phase == 1) begin
                long_hold_req = 1;
            end
            send_bytes();
        end

        wait_drained();
        if (tracker.expected_glyphs.size() != 0) begin
            tracker.report("results never delivered", 0, tracker.expected_glyphs.size());
        end
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end
        else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ===== utf8_glyph_address_mapper_top.f =====
design/uga_pkg.sv
design/uga_byte_if.sv
design/uga_glyph_if.sv
design/uga_front.sv
design/uga_queue.sv
design/uga_back.sv
design/utf8_glyph_address_mapper_top.sv
tb/tb_utf8_glyph_address_mapper_top.sv
